/* src/speck128_ofb_stream_cipher_assert.svh */
// Assertion macros shared by the Speck128 OFB cipher modules.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef SPECK128_OFB_STREAM_CIPHER_ASSERT_SVH
`define SPECK128_OFB_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define SOFB_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while in reset.
`define SOFB_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sofb_pkg.sv */
// Shared types, constants and round functions for the Speck128 OFB cipher.
// No dependencies.
package sofb_pkg;

  localparam int WORD_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 4;
  localparam int ROUND_COUNT = 32;
  localparam int RND_W       = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int CFG_INDEX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_ZERO = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_ONE  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_IV_WORD_ZERO  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_IV_WORD_ONE   = CFG_INDEX_W'(3);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    word_t key0;
    word_t key1;
    word_t iv0;
    word_t iv1;
  } cfg_t;

  // One queued word, tagged by the front end
  typedef struct packed {
    byte_t data;
    logic  start;   // reload feedback from IV
    logic  enc;     // group start: encipher feedback first
    pos_t  pos;     // keystream byte position
  } item_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } pair_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } core_state_t;

  function automatic pair_t speck_round(word_t x, word_t y, word_t k);
    pair_t r;
    r.x = ({x[7:0], x[WORD_W-1:8]} + y) ^ k;
    r.y = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ r.x;
    return r;
  endfunction

  // Keystream byte: word 0 then word 1, most significant byte first
  function automatic byte_t ks_byte(word_t fb0, word_t fb1, pos_t pos);
    word_t      w;
    logic [2:0] idx;
    w   = pos[POS_W-1] ? fb1 : fb0;
    idx = ~pos[2:0];
    return byte_t'(w >> {idx, 3'b000});
  endfunction

endpackage

/* src/sofb_front.sv */
// Front end: accepts input words, tracks keystream position, tags group starts,
// and buffers tagged words in a short queue. Depends on sofb_pkg.
`include "speck128_ofb_stream_cipher_assert.svh"

module sofb_front import sofb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t data_byte,
  input  logic  start_message,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  pos_t              pos;
  pos_t              pos_eff;
  item_t             item_in;
  logic              accept;

  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign accept   = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rptr];

  // start resets position before this byte
  assign pos_eff       = start_message ? '0 : pos;
  assign item_in.data  = data_byte;
  assign item_in.start = start_message;
  assign item_in.enc   = (pos_eff == '0);
  assign item_in.pos   = pos_eff;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      pos   <= '0;
    end else begin
      if (accept) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
        pos  <= pos_eff + 1'b1;
      end
      if (q_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (accept && !q_pop) begin
        count <= count + 1'b1;
      end else if (!accept && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `SOFB_CHECK_NOW(front_count_bound, 1'b1, count <= QCNT_W'(QDEPTH), "queue count over depth")
  `SOFB_CHECK_NOW(front_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `SOFB_CHECK_NEXT(front_start_pos, accept && start_message, pos == pos_t'(1), "position not restarted")

endmodule

/* src/sofb_core.sv */
// Back end: runs the Speck128 rounds on the feedback value, one per cycle,
// and XORs keystream into queued words through an output register. Depends on sofb_pkg.
`include "speck128_ofb_stream_cipher_assert.svh"

module sofb_core import sofb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_byte
);

  core_state_t      state, state_next;
  word_t            fb0, fb1;        // fb0 = y half, fb1 = x half
  word_t            kk, ll;          // round key and schedule partner
  logic [RND_W-1:0] rnd;
  logic             out_free;
  logic             start_run;
  pair_t            data_rnd, key_rnd;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

  assign out_free = !out_valid || out_ready;
  assign data_rnd = speck_round(fb1, fb0, kk);
  assign key_rnd  = speck_round(ll, kk, {{(WORD_W - RND_W){1'b0}}, rnd});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_item.enc) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (rnd == RND_LAST) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    start_run = 1'b0;
    case (state)
      ST_IDLE: begin
        start_run = q_valid && q_item.enc;
        q_pop     = q_valid && !q_item.enc && out_free;
      end
      ST_EMIT: begin
        q_pop = out_free;
      end
      default: begin
        q_pop     = 1'b0;
        start_run = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fb0       <= '0;
      fb1       <= '0;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_run) begin
        if (q_item.start) begin
          fb0 <= cfg.iv0;
          fb1 <= cfg.iv1;
        end
        rnd <= '0;
      end else if (state == ST_RUN) begin
        fb0 <= data_rnd.y;
        fb1 <= data_rnd.x;
        rnd <= rnd + 1'b1;
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Key schedule runs one step ahead of the data round
  always_ff @(posedge clk) begin
    if (start_run) begin
      kk <= cfg.key0;
      ll <= cfg.key1;
    end else if (state == ST_RUN) begin
      kk <= key_rnd.y;
      ll <= key_rnd.x;
    end
    if (q_pop) begin
      out_byte <= q_item.data ^ ks_byte(fb0, fb1, q_item.pos);
    end
  end

  `SOFB_CHECK_NOW(core_no_pop_in_run, state == ST_RUN, !q_pop, "word emitted mid-encipher")
  `SOFB_CHECK_NEXT(core_run_to_emit, state == ST_RUN && rnd == RND_LAST, state == ST_EMIT,
    "encipher did not finish")
  `SOFB_CHECK_NEXT(core_group_starts, state == ST_IDLE && q_valid && q_item.enc,
    state == ST_RUN && rnd == '0, "group start did not encipher")

endmodule

/* src/speck128_ofb_stream_cipher.sv */
// Top level of the Speck128/128 OFB byte stream cipher.
// Holds the configuration registers; instantiates sofb_front and sofb_core. Uses sofb_pkg.
//
// Each input word is one data byte; each output word is that byte XORed with the
// next keystream byte. The keystream is the 128-bit feedback value, enciphered
// with 32 Speck128 rounds at the start of every 16-byte group: feedback word 0
// most significant byte first, then word 1. A word with start_message set reloads
// the feedback from the IV registers and restarts at byte 0. A byte that opens a
// group passes from the head of the queue to the output register through a setup
// state, the 32 rounds on one data round unit and an emit state that waits for a
// free output register; other bytes go straight from the queue to the output
// register whenever it is free. The round unit, one round per cycle with the key
// schedule computed in parallel one step ahead, limits throughput. A two-word
// queue between the front end and the cipher core keeps input words flowing
// while the core is enciphering or the output is stalled. Configuration writes
// are always accepted (cfg_ready is tied high) and must only come while the block
// is idle; a key change applies at the next group, an IV change at the next start.
// Writes to indexes beyond the four registers are ignored.

module speck128_ofb_stream_cipher import sofb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  byte_t                  data_byte,
  input  logic                   start_message,
  output logic                   out_valid,
  input  logic                   out_ready,
  output byte_t                  out_byte,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  word_t                  cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_WORD_ZERO: cfg.key0 <= cfg_data;
        REG_KEY_WORD_ONE:  cfg.key1 <= cfg_data;
        REG_IV_WORD_ZERO:  cfg.iv0  <= cfg_data;
        REG_IV_WORD_ONE:   cfg.iv1  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: position tracking and queue
  sofb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_message (start_message),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Back: round engine and output register
  sofb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte)
  );

endmodule
